>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: always");

`define ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, prop)
`define ASSERT_IMPLY(label, cond, prop)
`define ASSERT_NEXT(label, cond, prop)

`endif

`endif

>>> rtl/mbde_pkg.sv
// ---------------------------------------------------------------------------
// mbde_pkg
// Types and constants shared by the button debounce event block.
// ---------------------------------------------------------------------------
`default_nettype none

package mbde_pkg;

    localparam int BUTTON_SLOTS = 24;
    localparam int CNT_W        = 8;
    localparam int NUM_W        = 5;
    localparam int PIN_W        = 24;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd5;
    localparam logic [CNT_W-1:0] LONG_RST     = 8'd100;
    localparam logic [CNT_W-1:0] DELAY_RST    = 8'd50;
    localparam logic [CNT_W-1:0] PERIOD_RST   = 8'd10;
    localparam logic [PIN_W-1:0] ACTIVE_RST   = 24'h000000;
    localparam logic [PIN_W-1:0] ENABLE_RST   = 24'hFFFFFF;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_LONG    = 2'd1,
        EV_RELEASE = 2'd2,
        EV_REPEAT  = 2'd3
    } ev_kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_LONG     = 3'd1,
        CFG_DELAY    = 3'd2,
        CFG_PERIOD   = 3'd3,
        CFG_ACTIVE   = 3'd4,
        CFG_ENABLE   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // scan token and repeat bookkeeping handed from cell to cell
    typedef struct packed {
        logic             tok;
        logic [NUM_W-1:0] rb;
        logic             arm;
    } link_t;

    // event offered by a cell, all zero when not valid
    typedef struct packed {
        logic             valid;
        ev_kind_t         kind;
        logic [NUM_W-1:0] num;
    } ev_t;

endpackage

`default_nettype wire

>>> rtl/mbde_cell.sv
// ---------------------------------------------------------------------------
// mbde_cell
// One button: hold counter, press/long/release decision on the scan token,
// and repeat bookkeeping passed on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module mbde_cell
    import mbde_pkg::*;
#(
    parameter int INDEX = 0
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             pin,
    input  wire logic             act,
    input  wire logic             btn_en,
    input  wire logic [CNT_W-1:0] deb,
    input  wire logic [CNT_W-1:0] lng,
    input  wire link_t            link_in,
    output link_t                 link_out,
    output ev_t                   ev
);

    localparam logic [NUM_W-1:0] NUM = NUM_W'(INDEX + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    link_t            link_reg, link_next;
    logic [CNT_W:0]   inc;
    logic             pressed;

    assign pressed = (pin == act);
    assign inc     = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        cnt_next  = cnt_reg;
        link_next = link_in;
        ev        = '0;
        if (link_in.tok && btn_en)
        begin
            if (pressed)
            begin
                if (inc > {1'b0, lng})
                begin
                    cnt_next = lng;
                end
                else if (inc == {1'b0, lng})
                begin
                    cnt_next = inc[CNT_W-1:0];
                    ev       = '{valid: 1'b1, kind: EV_LONG, num: NUM};
                end
                else if (inc == {1'b0, deb})
                begin
                    cnt_next      = inc[CNT_W-1:0];
                    ev            = '{valid: 1'b1, kind: EV_PRESS, num: NUM};
                    link_next.rb  = NUM;
                    link_next.arm = 1'b1;
                end
                else
                begin
                    cnt_next = inc[CNT_W-1:0];
                end
            end
            else if (cnt_reg >= deb)
            begin
                cnt_next = '0;
                ev       = '{valid: 1'b1, kind: EV_RELEASE, num: NUM};
                if (link_in.rb == NUM)
                begin
                    link_next.rb = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            link_reg <= '0;
        end
        else if (en)
        begin
            cnt_reg  <= cnt_next;
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

>>> rtl/multi_button_debounce_events.sv
// ---------------------------------------------------------------------------
// multi_button_debounce_events
// Debounce a bank of buttons and stream press, long press, release and
// auto-repeat events, one word per event, tlast on the final one of a tick.
// ---------------------------------------------------------------------------
// Scan: a scan token walks the cell chain one button per cycle unless the
//   output stalls it; the final word of a tick goes from the pending
//   register into the output register after the token leaves the tail.
// Flow: one tick at a time, with or without events; s_tready returns once
//   the final word is registered.
// Reset: all hold counters clear, repeat disarmed, config registers at defaults.
`default_nettype none

`include "assert_macros.svh"

module multi_button_debounce_events
    import mbde_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_SLOTS
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIN_W-1:0]      s_tdata,   // [23:0] pin_levels
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [1:0] event_kind, [6:2] button_number
    output logic                       m_tlast    // last_of_tick
);

    logic [CNT_W-1:0] deb_reg, lng_reg, delay_reg, period_reg;
    logic [PIN_W-1:0] act_reg, ena_reg;
    logic [PIN_W-1:0] pins_reg;

    state_t state_reg, state_next;

    logic             start_reg;
    logic [NUM_W-1:0] rb_reg;
    logic [CNT_W-1:0] cd_reg;

    ev_t              pend_reg;
    logic             m_tvalid_reg;
    logic [1:0]       m_kind_reg;
    logic [NUM_W-1:0] m_num_reg;
    logic             m_last_reg;

    link_t links [BUTTON_COUNT+1];
    ev_t   cell_ev [BUTTON_COUNT];
    logic [BUTTON_COUNT:0] tok_vec;

    ev_t              bus_ev, rep_ev, ev_now;
    logic [CNT_W-1:0] cd_base, cd_dec;
    logic             out_free, adv, chain_en, flush_push, ev_push;
    link_t            tail;

    // -- configuration -----------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg    <= DEBOUNCE_RST;
            lng_reg    <= LONG_RST;
            delay_reg  <= DELAY_RST;
            period_reg <= PERIOD_RST;
            act_reg    <= ACTIVE_RST;
            ena_reg    <= ENABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DEBOUNCE: deb_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_LONG:     lng_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_DELAY:    delay_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_PERIOD:   period_reg <= cfg_wdata[CNT_W-1:0];
                CFG_ACTIVE:   act_reg    <= cfg_wdata[PIN_W-1:0];
                CFG_ENABLE:   ena_reg    <= cfg_wdata[PIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // -- cell chain ------------------------------------------------------
    assign links[0] = '{tok: start_reg, rb: rb_reg, arm: 1'b0};
    assign tail     = links[BUTTON_COUNT];

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_cell
        mbde_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (chain_en),
            .pin      (pins_reg[i]),
            .act      (act_reg[i]),
            .btn_en   (ena_reg[i]),
            .deb      (deb_reg),
            .lng      (lng_reg),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .ev       (cell_ev[i])
        );
        assign tok_vec[i] = links[i].tok;
    end
    assign tok_vec[BUTTON_COUNT] = tail.tok;

    always_comb
    begin
        bus_ev = '0;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            bus_ev = ev_t'(bus_ev | cell_ev[i]);
        end
    end

    // -- repeat stage at the chain tail -----------------------------------
    assign cd_base = tail.arm ? delay_reg : cd_reg;
    assign cd_dec  = cd_base - {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        rep_ev = '0;
        if (tail.tok && (tail.rb != '0) && (cd_dec == '0))
        begin
            rep_ev = '{valid: 1'b1, kind: EV_REPEAT, num: tail.rb};
        end
    end

    assign ev_now   = tail.tok ? rep_ev : bus_ev;
    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = !(ev_now.valid && pend_reg.valid && !out_free);

    // -- control -------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.tok && adv)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_reg.valid || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        chain_en   = 1'b0;
        ev_push    = 1'b0;
        flush_push = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:
            begin
                chain_en = adv;
                ev_push  = adv && ev_now.valid && pend_reg.valid;
            end
            ST_FLUSH: flush_push = pend_reg.valid && out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            rb_reg    <= '0;
            cd_reg    <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_tvalid && s_tready)
            begin
                start_reg <= 1'b1;
            end
            else if (chain_en)
            begin
                start_reg <= 1'b0;
            end
            if (chain_en && tail.tok)
            begin
                rb_reg <= tail.rb;
                if (tail.rb != '0)
                begin
                    cd_reg <= (cd_dec == '0) ? period_reg : cd_dec;
                end
            end
            if (chain_en && ev_now.valid)
            begin
                pend_reg <= ev_now;
            end
            else if (flush_push)
            begin
                pend_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pins_reg <= s_tdata;
        end
    end

    // -- output register ---------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ev_push || flush_push)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_push || flush_push)
        begin
            m_kind_reg <= pend_reg.kind;
            m_num_reg  <= pend_reg.num;
            m_last_reg <= flush_push;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_num_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;

    // -- checks ----------------------------------------------------------------
    `ASSERT_ALWAYS(a_one_token, $onehot0(tok_vec))
    `ASSERT_IMPLY(a_idle_empty, s_tready, (tok_vec == '0) && !pend_reg.valid && !start_reg)
    `ASSERT_NEXT(a_flush_last, flush_push, m_tvalid && m_tlast)
    `ASSERT_ALWAYS(a_rb_range, rb_reg <= NUM_W'(BUTTON_COUNT))
    `ASSERT_NEXT(a_push_clears, ev_push, m_tvalid && !m_tlast)

endmodule

`default_nettype wire
